// File: rtl/dawm_pkg.sv
`default_nettype none

package dawm_pkg;

  localparam int IN_W   = 11;
  localparam int MAG_W  = 7;
  localparam int WMAG_W = 10;
  localparam int SQ_W   = 14;
  localparam int DUTY_W = 9;
  localparam int SUM_W  = 10;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIXING_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKING_ON    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_STEERING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LEFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_RIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_WEAPON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEAPON_STYLE  = 3'd6;

  // 2^16 / 9 and 2^20 / 100, rounded up
  localparam logic [12:0] RECIP9   = 13'd7282;
  localparam logic [13:0] RECIP100 = 14'd10486;

  localparam logic [MAG_W-1:0]  DRIVE_LIM  = 7'd100;
  localparam logic [MAG_W-1:0]  DRIVE_DEAD = 7'd10;
  localparam logic [WMAG_W-1:0] WPN_DEAD   = 10'd20;
  localparam logic [WMAG_W-1:0] WPN_HARD   = 10'd70;
  localparam logic [WMAG_W-1:0] WPN_LIM    = 10'd200;
  localparam logic [7:0]        THR_BIG    = 8'd20;
  localparam logic signed [DUTY_W-1:0] WPN_FULL = 9'sd200;
  localparam logic signed [DUTY_W-1:0] WPN_BACK = -9'sd40;

  typedef struct packed {
    logic mixing_on;
    logic braking_on;
    logic full_steering;
    logic flip_left;
    logic flip_right;
    logic flip_weapon;
    logic weapon_style;
  } cfg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] throttle_in;
    logic signed [IN_W-1:0] steering_in;
    logic signed [IN_W-1:0] weapon_in;
    logic                   upside_down;
  } in_t;

  typedef struct packed {
    logic              thr_neg;
    logic [MAG_W-1:0]  thr_mag;
    logic              str_neg;
    logic [MAG_W-1:0]  str_mag;
    logic              wpn_neg;
    logic [WMAG_W-1:0] wpn_mag;
    logic              upside_down;
  } scaled_t;

  typedef struct packed {
    scaled_t          sc;
    logic [SQ_W-1:0]  thr_sq;
    logic [SQ_W-1:0]  str_sq;
  } squared_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  left;
    logic signed [SUM_W-1:0]  right;
    logic signed [DUTY_W-1:0] weapon;
    logic                     upside_down;
  } mixed_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] left_duty;
    logic signed [DUTY_W-1:0] right_duty;
    logic signed [DUTY_W-1:0] weapon_duty;
    logic                     left_brake;
    logic                     right_brake;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/dawm_scale.sv
`default_nettype none

module dawm_scale (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire dawm_pkg::in_t    in_data,
  output logic                  out_valid,
  output dawm_pkg::scaled_t     out_data
);
  import dawm_pkg::*;

  logic [IN_W-1:0]   thr_abs;
  logic [IN_W-1:0]   str_abs;
  logic [IN_W-1:0]   wpn_abs;
  logic [24:0]       thr_prod;
  logic [24:0]       str_prod;
  logic [25:0]       wpn_prod;
  scaled_t           out_data_next;

  function automatic logic [MAG_W-1:0] clamp_dead(input logic [8:0] q);
    logic [MAG_W-1:0] r;
    if (q > 9'(DRIVE_LIM)) begin
      r = DRIVE_LIM;
    end else if (q < 9'(DRIVE_DEAD)) begin
      r = '0;
    end else begin
      r = q[MAG_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    thr_abs = in_data.throttle_in[IN_W-1] ? IN_W'(-in_data.throttle_in) : in_data.throttle_in;
    str_abs = in_data.steering_in[IN_W-1] ? IN_W'(-in_data.steering_in) : in_data.steering_in;
    wpn_abs = in_data.weapon_in[IN_W-1] ? IN_W'(-in_data.weapon_in) : in_data.weapon_in;
    // x*10/45 = x*2/9, x*20/45 = x*4/9, on magnitudes so truncation is toward zero
    thr_prod = 25'({thr_abs, 1'b0}) * 25'(RECIP9);
    str_prod = 25'({str_abs, 1'b0}) * 25'(RECIP9);
    wpn_prod = 26'({wpn_abs, 2'b00}) * 26'(RECIP9);
    out_data_next.thr_neg     = in_data.throttle_in[IN_W-1];
    out_data_next.thr_mag     = clamp_dead(thr_prod[24:16]);
    out_data_next.str_neg     = in_data.steering_in[IN_W-1];
    out_data_next.str_mag     = clamp_dead(str_prod[24:16]);
    out_data_next.wpn_neg     = in_data.weapon_in[IN_W-1];
    out_data_next.wpn_mag     = wpn_prod[25:16];
    out_data_next.upside_down = in_data.upside_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dawm_square.sv
`default_nettype none

module dawm_square (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire dawm_pkg::scaled_t  in_data,
  output logic                    out_valid,
  output dawm_pkg::squared_t      out_data
);
  import dawm_pkg::*;

  squared_t out_data_next;

  always_comb begin
    out_data_next.sc     = in_data;
    out_data_next.thr_sq = SQ_W'(in_data.thr_mag) * SQ_W'(in_data.thr_mag);
    out_data_next.str_sq = SQ_W'(in_data.str_mag) * SQ_W'(in_data.str_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dawm_mix.sv
`default_nettype none

module dawm_mix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire dawm_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  input  wire dawm_pkg::squared_t in_data,
  output logic                    out_valid,
  output dawm_pkg::mixed_t        out_data
);
  import dawm_pkg::*;

  logic [27:0]             thr_prod;
  logic [27:0]             str_prod;
  logic [7:0]              thr_q;
  logic [7:0]              str_q;
  logic [7:0]              str_use;
  logic [7:0]              thr_proc;
  logic signed [SUM_W-1:0] thr_val;
  logic signed [SUM_W-1:0] str_val;
  logic [7:0]              wpn_clip;
  logic signed [DUTY_W-1:0] wpn_signed;
  mixed_t                  out_data_next;

  always_comb begin
    // squared / 100 by reciprocal
    thr_prod = 28'(in_data.thr_sq) * 28'(RECIP100);
    str_prod = 28'(in_data.str_sq) * 28'(RECIP100);
    thr_q    = thr_prod[27:20];
    str_q    = str_prod[27:20];
    str_use  = cfg.full_steering ? str_q : (str_q >> 1);

    if (cfg.mixing_on) begin
      thr_val  = in_data.sc.thr_neg ? -$signed({2'b00, thr_q}) : $signed({2'b00, thr_q});
      str_val  = in_data.sc.str_neg ? -$signed({2'b00, str_use}) : $signed({2'b00, str_use});
      thr_proc = thr_q;
      out_data_next.left  = thr_val + str_val;
      out_data_next.right = thr_val - str_val;
    end else begin
      thr_val  = in_data.sc.thr_neg ? -$signed({3'b000, in_data.sc.thr_mag})
                                    : $signed({3'b000, in_data.sc.thr_mag});
      str_val  = in_data.sc.str_neg ? -$signed({3'b000, in_data.sc.str_mag})
                                    : $signed({3'b000, in_data.sc.str_mag});
      thr_proc = {1'b0, in_data.sc.thr_mag};
      out_data_next.left  = str_val;
      out_data_next.right = thr_val;
    end

    // weapon shaping
    wpn_clip   = (in_data.sc.wpn_mag > WPN_LIM) ? WPN_LIM[7:0] : in_data.sc.wpn_mag[7:0];
    wpn_signed = in_data.sc.wpn_neg ? -$signed({1'b0, wpn_clip}) : $signed({1'b0, wpn_clip});
    if (cfg.weapon_style) begin
      if (in_data.sc.wpn_mag > WPN_HARD) begin
        out_data_next.weapon = in_data.sc.wpn_neg ? wpn_signed : WPN_FULL;
      end else if (thr_proc > THR_BIG) begin
        out_data_next.weapon = WPN_BACK;
      end else begin
        out_data_next.weapon = '0;
      end
    end else begin
      out_data_next.weapon = (in_data.sc.wpn_mag < WPN_DEAD) ? '0 : wpn_signed;
    end

    out_data_next.upside_down = in_data.sc.upside_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dawm_drive_out.sv
`default_nettype none

module dawm_drive_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire dawm_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  input  wire dawm_pkg::mixed_t in_data,
  output logic                  out_valid,
  output dawm_pkg::out_t        out_data
);
  import dawm_pkg::*;

  logic signed [DUTY_W-1:0] left_c;
  logic signed [DUTY_W-1:0] right_c;
  logic signed [DUTY_W-1:0] left_pre;
  logic signed [DUTY_W-1:0] right_pre;
  logic signed [DUTY_W-1:0] left_fin;
  logic signed [DUTY_W-1:0] right_fin;
  out_t                     out_data_next;

  function automatic logic signed [DUTY_W-1:0] clamp_dbl(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] c;
    if (x > $signed(SUM_W'(DRIVE_LIM))) begin
      c = $signed(SUM_W'(DRIVE_LIM));
    end else if (x < -$signed(SUM_W'(DRIVE_LIM))) begin
      c = -$signed(SUM_W'(DRIVE_LIM));
    end else begin
      c = x;
    end
    return $signed({c[DUTY_W-2:0], 1'b0});
  endfunction

  always_comb begin
    left_c    = clamp_dbl(in_data.left);
    right_c   = clamp_dbl(in_data.right);
    left_pre  = in_data.upside_down ? -right_c : left_c;
    right_pre = in_data.upside_down ? -left_c : right_c;
    left_fin  = cfg.flip_left ? -left_pre : left_pre;
    right_fin = cfg.flip_right ? -right_pre : right_pre;
    out_data_next.left_duty   = left_fin;
    out_data_next.right_duty  = right_fin;
    out_data_next.weapon_duty = cfg.flip_weapon ? -in_data.weapon : in_data.weapon;
    out_data_next.left_brake  = cfg.braking_on && (left_fin == '0);
    out_data_next.right_brake = cfg.braking_on && (right_fin == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drive_and_weapon_mixer.sv
// Drive and weapon mixer: turns centred stick offsets into motor duties.
// Input stream (s_*): one word per stick sample; tdata holds throttle_in,
// steering_in and weapon_in, tuser holds the upside_down flag.
// Output stream (m_*): one word per sample with left, right and weapon
// duties in tdata and the two brake flags in tuser.
// Configuration: cfg_we writes bit 0 of cfg_data to the register chosen by
// cfg_index (0 mixing_on .. 6 weapon_style); other indexes are ignored.
// Write it only while no sample is in flight.
// From input handshake to output valid a sample passes four registers:
// scale by reciprocal multiply, square, divide by 100 and mix, then clamp and flip.
// One sample per cycle while not stalled; the four stages move together.
// When the receiver holds m_tready low with a word waiting, the whole
// pipeline holds and s_tready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the register defaults:
// mixing and braking on, left flip on, everything else off.
`default_nettype none

module drive_and_weapon_mixer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // throttle_in[10:0], steering_in[21:11], weapon_in[32:22], zero pad
  input  wire logic [39:0] s_tdata,
  // upside_down
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // left_duty[8:0], right_duty[17:9], weapon_duty[26:18], zero pad
  output logic [31:0]      m_tdata,
  // left_brake[0], right_brake[1]
  output logic [1:0]       m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [dawm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        cfg_data
);
  import dawm_pkg::*;

  cfg_t     cfg;
  in_t      in_data;
  logic     en;
  logic     s1_valid;
  logic     s2_valid;
  logic     s3_valid;
  logic     s4_valid;
  scaled_t  s1_data;
  squared_t s2_data;
  mixed_t   s3_data;
  out_t     s4_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mixing_on     <= 1'b1;
      cfg.braking_on    <= 1'b1;
      cfg.full_steering <= 1'b0;
      cfg.flip_left     <= 1'b1;
      cfg.flip_right    <= 1'b0;
      cfg.flip_weapon   <= 1'b0;
      cfg.weapon_style  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIXING_ON:     cfg.mixing_on     <= cfg_data;
        REG_BRAKING_ON:    cfg.braking_on    <= cfg_data;
        REG_FULL_STEERING: cfg.full_steering <= cfg_data;
        REG_FLIP_LEFT:     cfg.flip_left     <= cfg_data;
        REG_FLIP_RIGHT:    cfg.flip_right    <= cfg_data;
        REG_FLIP_WEAPON:   cfg.flip_weapon   <= cfg_data;
        REG_WEAPON_STYLE:  cfg.weapon_style  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign en       = !s4_valid || m_tready;
  assign s_tready = en;

  assign in_data.throttle_in = $signed(s_tdata[10:0]);
  assign in_data.steering_in = $signed(s_tdata[21:11]);
  assign in_data.weapon_in   = $signed(s_tdata[32:22]);
  assign in_data.upside_down = s_tuser[0];

  dawm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  dawm_square u_square (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  dawm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_data  (s3_data)
  );

  dawm_drive_out u_drive_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s3_valid),
    .in_data   (s3_data),
    .out_valid (s4_valid),
    .out_data  (s4_data)
  );

  assign m_tvalid = s4_valid;
  assign m_tdata  = {5'b00000, s4_data.weapon_duty, s4_data.right_duty, s4_data.left_duty};
  assign m_tuser  = {s4_data.right_brake, s4_data.left_brake};

endmodule

`default_nettype wire
